// File: sv/pncq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pncq_pkg
// Shared types and constants for the nearest palette color quantizer.
// ----------------------------------------------------------------------------
package pncq_pkg;

    localparam int MAX_COLORS = 64;
    localparam int GROUP_SIZE = 4;
    localparam int COUNT_BITS = 18;
    localparam int NUM_GROUPS = (MAX_COLORS + GROUP_SIZE - 1) / GROUP_SIZE;

    localparam int IDX_W = $clog2(MAX_COLORS);
    localparam int LIM_W = IDX_W + 1;
    localparam int GRP_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

    localparam int CFG_W      = 7;
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PALETTE_SIZE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GRAY_LEVEL   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GRAY_ENTRIES = 2'd2;

    localparam logic [CFG_W-1:0] PALETTE_SIZE_RST = 7'd64;
    localparam logic [CFG_W-1:0] GRAY_LEVEL_RST   = 7'd100;
    localparam logic [CFG_W-1:0] GRAY_ENTRIES_RST = 7'd12;
    localparam logic [CFG_W-1:0] PCT_FULL         = 7'd100;

    localparam logic [1:0] REQ_WRITE    = 2'd0;
    localparam logic [1:0] REQ_CLASSIFY = 2'd1;
    localparam logic [1:0] REQ_CLEAR    = 2'd2;

    localparam logic [7:0] ALPHA_LIMIT = 8'd128;

    // distance datapath widths
    localparam int SQ_W   = 18;   // sum of three squared 8-bit differences
    localparam int PEN_W  = 11;   // 15 * (100 - gray level)
    localparam int PROD_W = SQ_W + PEN_W;
    localparam int DIST_W = 22;   // d + d*1500/100 stays below 2^22

    localparam logic [PEN_W-1:0]  PEN_WEIGHT = 11'd15;
    localparam logic [DIST_W-1:0] START_DIST = 22'd200000;

    // floor(x/100) = (x * ceil(2^36/100)) >> 36, exact for x < 2^30
    localparam int RECIP_W     = 30;
    localparam int RECIP_SHIFT = 36;
    localparam logic [RECIP_W-1:0] RECIP_100 = 30'd687194768;

    typedef struct packed {
        logic [1:0] req_type;
        logic [5:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } in_word_t;

    typedef struct packed {
        logic        visible;
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic [7:0]  out_alpha;
        logic [5:0]  chosen_index;
        logic [17:0] group_total;
    } out_word_t;

    typedef struct packed {
        logic             accept;
        logic             mem_write;
        logic             hist_clear;
        logic             scan_issue;
        logic [IDX_W-1:0] scan_addr;
        logic             fetch;
        logic             load_result;
        logic             result_visible;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0]       req_type;
        logic             opaque;
        logic [LIM_W-1:0] scan_limit;
        logic             pipe_busy;
        logic             out_free;
    } dp_status_t;

endpackage
`default_nettype wire

// File: sv/pncq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pncq_ctrl
// Sequencer: takes a word, walks the palette one entry a cycle, waits for the
// distance pipeline to drain, fetches the winner and hands off the result.
// ----------------------------------------------------------------------------
module pncq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pncq_pkg::dp_status_t status,
    output pncq_pkg::ctrl_cmd_t  cmd
);
    import pncq_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_FETCH  = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [LIM_W-1:0] cnt_reg, cnt_next;
    logic             vis_reg, vis_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            vis_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            vis_reg   <= vis_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        vis_next   = vis_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    case (status.req_type)
                        REQ_WRITE: cmd.mem_write = 1'b1;
                        REQ_CLEAR: cmd.hist_clear = 1'b1;
                        REQ_CLASSIFY: begin
                            cnt_next = '0;
                            if (!status.opaque) begin
                                vis_next   = 1'b0;
                                state_next = ST_RESULT;
                            end else if (status.scan_limit == '0) begin
                                vis_next   = 1'b1;
                                state_next = ST_FETCH;
                            end else begin
                                vis_next   = 1'b1;
                                state_next = ST_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                cmd.scan_addr  = cnt_reg[IDX_W-1:0];
                cnt_next       = cnt_reg + LIM_W'(1);
                if (cnt_reg + LIM_W'(1) == status.scan_limit) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd.load_result    = 1'b1;
                    cmd.result_visible = vis_reg;
                    state_next         = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_issue |-> cnt_reg < status.scan_limit)
        else $error("scan address past palette limit");

    a_fetch_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fetch |-> !status.pipe_busy)
        else $error("winner fetched while distances still in flight");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result |-> status.out_free)
        else $error("result loaded over a word not yet taken");
`endif

endmodule
`default_nettype wire

// File: sv/pncq_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pncq_dp
// Datapath: config registers, palette memory, five-stage weighted distance
// pipeline with running minimum, group histogram and output register.
// ----------------------------------------------------------------------------
module pncq_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_addr,
    input  logic [6:0]           cfg_wr_data,
    input  pncq_pkg::in_word_t   s_data,
    input  pncq_pkg::ctrl_cmd_t  cmd,
    output pncq_pkg::dp_status_t status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pncq_pkg::out_word_t  m_data
);
    import pncq_pkg::*;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] psize_reg, glevel_reg, gent_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            psize_reg  <= PALETTE_SIZE_RST;
            glevel_reg <= GRAY_LEVEL_RST;
            gent_reg   <= GRAY_ENTRIES_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_PALETTE_SIZE: psize_reg  <= cfg_wr_data;
                CFG_GRAY_LEVEL:   glevel_reg <= cfg_wr_data;
                CFG_GRAY_ENTRIES: gent_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    logic [LIM_W-1:0] scan_limit;
    logic [CFG_W-1:0] gl_clamped;
    logic [PEN_W-1:0] pen_k;

    assign scan_limit = (int'(psize_reg) > MAX_COLORS) ? LIM_W'(MAX_COLORS)
                                                       : LIM_W'(psize_reg);
    assign gl_clamped = (glevel_reg > PCT_FULL) ? PCT_FULL : glevel_reg;
    assign pen_k      = PEN_W'(PCT_FULL - gl_clamped) * PEN_WEIGHT;

    // ---------------- palette memory ----------------
    logic [31:0]      palette_mem [MAX_COLORS];
    logic [31:0]      rdata_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] win_reg;

    assign rd_en   = cmd.scan_issue | cmd.fetch;
    assign rd_addr = cmd.fetch ? win_reg : cmd.scan_addr;

    always_ff @(posedge aclk) begin
        if (cmd.mem_write && (int'(s_data.entry_index) < MAX_COLORS)) begin
            palette_mem[IDX_W'(s_data.entry_index)] <=
                {s_data.alpha, s_data.blue, s_data.green, s_data.red};
        end
        if (rd_en) begin
            rdata_reg <= palette_mem[rd_addr];
        end
    end

    // ---------------- pixel and search state ----------------
    logic [7:0]        px_r_reg, px_g_reg, px_b_reg;
    logic [DIST_W-1:0] best_reg;

    // ---------------- distance pipeline ----------------
    logic             v1_reg, v2_reg, v3_reg, v4_reg;
    logic [IDX_W-1:0] i1_reg, i2_reg, i3_reg, i4_reg;
    logic             pen2_reg;
    logic [SQ_W-1:0]  d2_reg, d3_reg, d4_reg;
    logic [PROD_W-1:0] prod3_reg;
    logic [DIST_W-1:0] q4_reg;

    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return 16'(d) * 16'(d);
    endfunction

    logic [SQ_W-1:0]          d2_next;
    logic [PEN_W-1:0]         k_eff;
    logic [PROD_W+RECIP_W-1:0] recip_prod;
    logic [DIST_W-1:0]        dist_sum;

    assign d2_next = SQ_W'(sq_diff(rdata_reg[7:0], px_r_reg))
                   + SQ_W'(sq_diff(rdata_reg[15:8], px_g_reg))
                   + SQ_W'(sq_diff(rdata_reg[23:16], px_b_reg));
    assign k_eff      = pen2_reg ? pen_k : '0;
    assign recip_prod = (PROD_W+RECIP_W)'(prod3_reg) * (PROD_W+RECIP_W)'(RECIP_100);
    assign dist_sum   = DIST_W'(d4_reg) + q4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.scan_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        i1_reg    <= cmd.scan_addr;
        i2_reg    <= i1_reg;
        pen2_reg  <= int'(i1_reg) < int'(gent_reg);
        d2_reg    <= d2_next;
        i3_reg    <= i2_reg;
        d3_reg    <= d2_reg;
        prod3_reg <= PROD_W'(d2_reg) * PROD_W'(k_eff);
        i4_reg    <= i3_reg;
        d4_reg    <= d3_reg;
        q4_reg    <= recip_prod[RECIP_SHIFT +: DIST_W];

        if (cmd.accept) begin
            px_r_reg <= s_data.red;
            px_g_reg <= s_data.green;
            px_b_reg <= s_data.blue;
            best_reg <= START_DIST;
            win_reg  <= '0;
        end else if (v4_reg && (dist_sum < best_reg)) begin
            best_reg <= dist_sum;
            win_reg  <= i4_reg;
        end
    end

    // ---------------- group histogram ----------------
    logic [COUNT_BITS-1:0] hist_reg [NUM_GROUPS];
    logic [COUNT_BITS-1:0] tot_reg;
    logic [GRP_W-1:0]      grp;
    logic [COUNT_BITS-1:0] hist_cur, hist_inc;

    assign grp      = GRP_W'(win_reg / GROUP_SIZE);
    assign hist_cur = hist_reg[grp];
    assign hist_inc = (hist_cur == '1) ? hist_cur : hist_cur + COUNT_BITS'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                hist_reg[g] <= '0;
            end
        end else if (cmd.hist_clear) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                hist_reg[g] <= '0;
            end
        end else if (cmd.fetch) begin
            hist_reg[grp] <= hist_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fetch) begin
            tot_reg <= hist_inc;
        end
    end

    // ---------------- output register ----------------
    logic      m_valid_reg;
    out_word_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            if (cmd.result_visible) begin
                m_data_reg.visible      <= 1'b1;
                m_data_reg.out_red      <= rdata_reg[7:0];
                m_data_reg.out_green    <= rdata_reg[15:8];
                m_data_reg.out_blue     <= rdata_reg[23:16];
                m_data_reg.out_alpha    <= rdata_reg[31:24];
                m_data_reg.chosen_index <= 6'(win_reg);
                m_data_reg.group_total  <= 18'(tot_reg);
            end else begin
                m_data_reg <= '0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign status.req_type   = s_data.req_type;
    assign status.opaque     = s_data.alpha >= ALPHA_LIMIT;
    assign status.scan_limit = scan_limit;
    assign status.pipe_busy  = v1_reg | v2_reg | v3_reg | v4_reg;
    assign status.out_free   = !m_valid_reg || m_ready;

`ifndef SYNTHESIS
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fetch |=> tot_reg != '0)
        else $error("group total zero after increment");

    a_best_monotone: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && !cmd.accept) |=> best_reg <= $past(best_reg))
        else $error("best distance grew during search");

    a_transparent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.visible) |->
            (m_data_reg.chosen_index == '0 && m_data_reg.group_total == '0 &&
             m_data_reg.out_alpha == '0 && m_data_reg.out_red == '0))
        else $error("transparent result carries nonzero fields");
`endif

endmodule
`default_nettype wire

// File: sv/palette_nearest_color_quantizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// palette_nearest_color_quantizer
// Maps RGBA pixels to the nearest entry of a loaded palette and keeps a
// per-group hit histogram.
// ----------------------------------------------------------------------------
// Write and clear words give no result. A classify word with alpha below 128
// goes straight to the result state and puts transparent black in the output
// register. For an opaque pixel the palette memory read port delivers one entry
// per cycle, min(palette_size, 64) entries in all (none when palette_size is
// zero), into a five-stage weighted distance pipeline, which then drains
// before the winner is fetched from the same port and its group count is
// bumped. A stalled output register holds the sequencer until it frees up. A
// new word is taken as soon as the sequencer is back in idle, even while the
// previous result still sits in the output register. The palette holds
// garbage until written; the histogram and config registers come out of
// reset cleared and at defaults.
// ----------------------------------------------------------------------------
module palette_nearest_color_quantizer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_addr,
    input  logic [6:0]          cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  pncq_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pncq_pkg::out_word_t m_data
);
    import pncq_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    pncq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pncq_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
`default_nettype wire
